@@ hw/rtl/assert_macros.svh @@
// assertion macros included by the gain table entry unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is active
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/slg_pkg.sv @@
// shared types and constants of the srgb gain table entry unit
`timescale 1ns / 1ps
`default_nettype none
package slg_pkg;

  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned ENTRY_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STRENGTH_W = 13;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned EFF_W      = 17;
  localparam int unsigned CODES      = 256;
  localparam logic [STRENGTH_W-1:0] STRENGTH_FULL = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE,
    REG_STRENGTH,
    REG_RED_GAIN,
    REG_GREEN_GAIN,
    REG_BLUE_GAIN,
    REG_CHANNEL_ORDER
  } reg_idx_e;

  typedef enum logic [2:0] {
    ORDER_RGB,
    ORDER_BGR,
    ORDER_GRB,
    ORDER_GBR,
    ORDER_RBG,
    ORDER_BRG
  } order_e;

  function automatic logic [ENTRY_W-1:0] pack_order(input logic [2:0] order,
                                                    input logic [7:0] r,
                                                    input logic [7:0] g,
                                                    input logic [7:0] b);
    logic [ENTRY_W-1:0] res;
    case (order_e'(order))
      ORDER_BGR: res = {b, g, r};
      ORDER_GRB: res = {g, r, b};
      ORDER_GBR: res = {g, b, r};
      ORDER_RBG: res = {r, b, g};
      ORDER_BRG: res = {b, r, g};
      default:   res = {r, g, b};
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/slg_in_if.sv @@
// input channel: one level per item
`timescale 1ns / 1ps
`default_nettype none
interface slg_in_if import slg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/slg_out_if.sv @@
// output channel: one packed table entry per item
`timescale 1ns / 1ps
`default_nettype none
interface slg_out_if import slg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] packed_entry;
  modport source (output valid, output packed_entry, input ready);
  modport sink (input valid, input packed_entry, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/srgb_linear_gain_lut_entry_unit.sv @@
// srgb level to white-balanced packed gamma table entry, deep pipeline
// throughput: one item per cycle while the output is not stalled; the eight-step threshold search per channel
//   is spread over eight register stages so no stage holds more than one compare
// reset: config registers return to enable 1, strength full, unity gains, rgb order;
//   the pipeline empties; both roms are constants so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module srgb_linear_gain_lut_entry_unit import slg_pkg::*; #(
  parameter int unsigned LUT_ENTRIES    = 256,
  parameter int unsigned LINEAR_BITS    = 16,
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  slg_in_if.sink                     in_i,
  slg_out_if.source                  out_o
);

  localparam int unsigned LIN_W     = LINEAR_BITS + 1;
  localparam int unsigned PROD_W    = LIN_W + EFF_W;
  localparam int unsigned IDX_W     = $clog2(LUT_ENTRIES);
  localparam int unsigned WORK_BITS = 30;
  localparam int unsigned NST       = 11;
  localparam int unsigned SRCH0     = 3;  // first search stage

  typedef logic [LIN_W-1:0] lin_rom_t [LUT_ENTRIES];
  typedef logic [LIN_W-1:0] thr_rom_t [CODES];

  // ---------------------------------------------------------------------------
  // elaboration-time rom build: fixed-point srgb decode
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] pow5(input logic [63:0] r);
    logic [63:0] m;
    m = r;
    for (int k = 0; k < 4; k++) m = (m * r) >> WORK_BITS;
    return m;
  endfunction

  function automatic logic [63:0] root5(input logic [63:0] u);
    logic [63:0] lo, hi, mid;
    lo = 64'd0;
    hi = 64'd1 << WORK_BITS;
    for (int it = 0; it < 32; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (pow5(mid) <= u) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // long division, only ever evaluated while building the roms
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] decode_frac(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] half, tden, tq, t2, r, tp, res;
    half = 64'd1 << (WORK_BITS - 1);
    if (num * 64'd100000 <= 64'd4045 * den) begin
      res = udiv(((num * 64'd100) << LINEAR_BITS) + 64'd646 * den, 64'd1292 * den);
    end else begin
      tden = 64'd1055 * den;
      tq   = udiv(((num * 64'd1000 + 64'd55 * den) << WORK_BITS) + (tden >> 1), tden);
      t2   = (tq * tq + half) >> WORK_BITS;
      r    = root5(t2);
      tp   = (t2 * r + half) >> WORK_BITS;
      res  = (tp + (64'd1 << (WORK_BITS - LINEAR_BITS - 1))) >> (WORK_BITS - LINEAR_BITS);
    end
    return res;
  endfunction

  function automatic lin_rom_t build_lin();
    lin_rom_t rom;
    for (int i = 0; i < LUT_ENTRIES; i++)
      rom[i] = LIN_W'(decode_frac(64'(i), 64'(LUT_ENTRIES - 1)));
    return rom;
  endfunction

  function automatic thr_rom_t build_thr();
    thr_rom_t rom;
    rom[0] = '0;
    for (int i = 1; i < CODES; i++)
      rom[i] = LIN_W'(decode_frac(64'(2 * i - 1), 64'd510));
    return rom;
  endfunction

  localparam lin_rom_t LinRom = build_lin();
  localparam thr_rom_t ThrRom = build_thr();

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic                  enable_q;
  logic [STRENGTH_W-1:0] strength_q;
  logic [GAIN_W-1:0]     gain_q [3];
  logic [2:0]            order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b1;
      strength_q <= STRENGTH_FULL;
      gain_q[0]  <= 16'd4096;
      gain_q[1]  <= 16'd4096;
      gain_q[2]  <= 16'd4096;
      order_q    <= 3'(ORDER_RGB);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ENABLE:        enable_q   <= cfg_wdata_i[0];
        REG_STRENGTH:      strength_q <= cfg_wdata_i[STRENGTH_W-1:0];
        REG_RED_GAIN:      gain_q[0]  <= cfg_wdata_i;
        REG_GREEN_GAIN:    gain_q[1]  <= cfg_wdata_i;
        REG_BLUE_GAIN:     gain_q[2]  <= cfg_wdata_i;
        REG_CHANNEL_ORDER: order_q    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // effective gain 1 + (gain - 1) * strength, rounded, registered so it follows config in the next cycle
  logic [STRENGTH_W-1:0] s_clamp;
  logic [EFF_W-1:0]      eff_d [3];
  logic [EFF_W-1:0]      eff_q [3];
  logic [31:0]           eff_sum [3];

  assign s_clamp = (strength_q > STRENGTH_FULL) ? STRENGTH_FULL : strength_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      eff_sum[c] = (32'(STRENGTH_FULL - s_clamp) << GAIN_FRAC_BITS)
                 + 32'(gain_q[c]) * 32'(s_clamp) + 32'd2048;
      eff_d[c]   = eff_sum[c][12 +: EFF_W];
    end
  end

  always_ff @(posedge clk_i) begin
    eff_q <= eff_d;
  end

  // ---------------------------------------------------------------------------
  // pipeline: stage 0 level, 1 linear lookup, 2 products, 3..10 search bits 7..0
  // ---------------------------------------------------------------------------
  logic               valid_q [NST];
  logic               rdy [NST+1];
  logic [LEVEL_W-1:0] level_q [NST];
  logic [LIN_W-1:0]   lin_q;
  logic [PROD_W-1:0]  prod_q [2:NST-1][3];
  logic [7:0]         code_q [SRCH0:NST-1][3];
  logic [IDX_W-1:0]   lin_idx;

  // a stage takes a new item when empty or when it hands its own item on
  always_comb begin
    rdy[NST] = out_o.ready;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !valid_q[i] || rdy[i+1];
  end

  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) valid_q[i] <= 1'b0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_i.valid;
      for (int i = 1; i < NST; i++) if (rdy[i]) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) level_q[0] <= in_i.level;
    for (int i = 1; i < NST; i++) if (rdy[i]) level_q[i] <= level_q[i-1];
  end

  // levels beyond the table use the last entry
  assign lin_idx = (32'(level_q[0]) < LUT_ENTRIES) ? IDX_W'(level_q[0])
                                                   : IDX_W'(LUT_ENTRIES - 1);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) lin_q <= LinRom[lin_idx];
    if (rdy[2]) begin
      for (int c = 0; c < 3; c++) prod_q[2][c] <= PROD_W'(lin_q) * PROD_W'(eff_q[c]);
    end
  end

  // binary search over the monotonic rounding thresholds, one bit per stage
  for (genvar j = 0; j < 8; j++) begin : g_search
    localparam int unsigned St  = SRCH0 + j;
    localparam int unsigned Bit = 7 - j;
    logic [7:0] base [3];
    logic [7:0] trial [3];
    logic [7:0] next [3];

    if (j == 0) begin : g_base
      always_comb begin
        for (int c = 0; c < 3; c++) base[c] = 8'd0;
      end
    end else begin : g_base
      always_comb begin
        for (int c = 0; c < 3; c++) base[c] = code_q[St-1][c];
      end
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = base[c] | (8'd1 << Bit);
        next[c]  = (prod_q[St-1][c] >= (PROD_W'(ThrRom[trial[c]]) << GAIN_FRAC_BITS))
                   ? trial[c] : base[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[St]) begin
        for (int c = 0; c < 3; c++) begin
          code_q[St][c] <= next[c];
          prod_q[St][c] <= prod_q[St-1][c];
        end
      end
    end
  end

  // output register is the last search stage; bypass gives identity entries
  assign out_o.valid        = valid_q[NST-1];
  assign out_o.packed_entry = enable_q
      ? pack_order(order_q, code_q[NST-1][0], code_q[NST-1][1], code_q[NST-1][2])
      : {level_q[NST-1], level_q[NST-1], level_q[NST-1]};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `ASSERT_CLK(a_backpressure_only_from_out, clk_i, rst_ni,
    !in_i.ready |-> (out_o.valid && !out_o.ready), "input stalled without output stall")
  `ASSERT_CLK(a_accept_fills_stage0, clk_i, rst_ni,
    (in_i.valid && in_i.ready) |=> valid_q[0], "accepted item lost at entry")
  `ASSERT_CLK(a_saturate_full_scale, clk_i, rst_ni,
    (valid_q[NST-1] && (prod_q[NST-1][0] >= (PROD_W'(1) << (LINEAR_BITS + GAIN_FRAC_BITS))))
      |-> (code_q[NST-1][0] == 8'd255), "product at full scale did not saturate")

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// testbench for the srgb gain table entry unit: predicted entries checked in order
`timescale 1ns / 1ps
`default_nettype none

// expected-entry store with its own copy of the registers and both roms
class entry_scoreboard;
  localparam int unsigned Q = 30;
  logic [31:0] lin_rom [256];
  logic [31:0] thr_rom [256];
  logic        enable;
  logic [12:0] strength;
  logic [15:0] r_gain, g_gain, b_gain;
  logic [2:0]  order;
  logic [23:0] expected_entries [$];
  int          mismatches;

  function new();
    lin_rom[0] = 0;
    for (int i = 0; i < 256; i++) lin_rom[i] = decode_code(i, 255);
    thr_rom[0] = 0;
    for (int i = 1; i < 256; i++) thr_rom[i] = decode_code(2 * i - 1, 510);
    enable = 1'b1;
    strength = 13'd4096;
    r_gain = 16'd4096;
    g_gain = 16'd4096;
    b_gain = 16'd4096;
    order = 3'd0;
    mismatches = 0;
  endfunction

  // r^5 with truncation to q30 after each multiply
  function automatic logic [63:0] fifth_power(logic [63:0] r);
    logic [63:0] m;
    m = r;
    for (int k = 0; k < 4; k++) m = (m * r) >> Q;
    return m;
  endfunction

  function automatic logic [31:0] decode_code(logic [63:0] num, logic [63:0] den);
    logic [63:0] half, tden, tq, t2, lo, hi, mid, tp;
    half = 64'd1 << (Q - 1);
    if (num * 100000 <= 4045 * den)
      return 32'(((num * 100 << 16) + 646 * den) / (1292 * den));
    tden = 1055 * den;
    tq = (((num * 1000 + 55 * den) << Q) + tden / 2) / tden;
    t2 = (tq * tq + half) >> Q;
    lo = 0;
    hi = 64'd1 << Q;
    // largest root whose fifth power stays at or below t2
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (fifth_power(mid) <= t2) lo = mid;
      else hi = mid - 1;
    end
    tp = (t2 * lo + half) >> Q;
    return 32'((tp + (64'd1 << (Q - 17))) >> (Q - 16));
  endfunction

  function automatic logic [63:0] blended_gain(logic [15:0] gain);
    logic [63:0] s;
    s = (strength > 13'd4096) ? 64'd4096 : 64'(strength);
    return (64'd4096 * (64'd4096 - s) + 64'(gain) * s + 64'd2048) >> 12;
  endfunction

  function automatic logic [7:0] linear_to_code(logic [63:0] p);
    logic [7:0] code;
    if (p >= (64'd1 << 28)) return 8'd255;
    code = 0;
    for (int k = 1; k < 256; k++)
      if (p >= (64'(thr_rom[k]) << 12)) code++;
    return code;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] data);
    case (slg_pkg::reg_idx_e'(idx))
      slg_pkg::REG_ENABLE:        enable = data[0];
      slg_pkg::REG_STRENGTH:      strength = data[12:0];
      slg_pkg::REG_RED_GAIN:      r_gain = data;
      slg_pkg::REG_GREEN_GAIN:    g_gain = data;
      slg_pkg::REG_BLUE_GAIN:     b_gain = data;
      slg_pkg::REG_CHANNEL_ORDER: order = data[2:0];
      default: ;
    endcase
  endfunction

  function void note_level(logic [7:0] level);
    logic [63:0] lin;
    logic [7:0]  r, g, b;
    if (!enable) begin
      expected_entries.push_back({level, level, level});
      return;
    end
    lin = 64'(lin_rom[level]);
    r = linear_to_code(lin * blended_gain(r_gain));
    g = linear_to_code(lin * blended_gain(g_gain));
    b = linear_to_code(lin * blended_gain(b_gain));
    case (slg_pkg::order_e'(order))
      slg_pkg::ORDER_BGR: expected_entries.push_back({b, g, r});
      slg_pkg::ORDER_GRB: expected_entries.push_back({g, r, b});
      slg_pkg::ORDER_GBR: expected_entries.push_back({g, b, r});
      slg_pkg::ORDER_RBG: expected_entries.push_back({r, b, g});
      slg_pkg::ORDER_BRG: expected_entries.push_back({b, r, g});
      default:            expected_entries.push_back({r, g, b});
    endcase
  endfunction

  function void check_entry(logic [23:0] actual);
    logic [23:0] want;
    if (expected_entries.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected entry %06h", actual);
      return;
    end
    want = expected_entries.pop_front();
    if (actual !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("entry mismatch: expected %06h, got %06h", want, actual);
    end
  endfunction

  function int pending();
    return expected_entries.size();
  endfunction
endclass

module tb_top;
  import slg_pkg::*;

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  bit   quiet = 1'b0;          // no idling in the closing phase

  slg_in_if  in_ch ();
  slg_out_if out_ch ();

  srgb_linear_gain_lut_entry_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  entry_scoreboard entries = new();

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.level = '0;
  end

  // register write, only while the pipeline is empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    entries.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // one level offered until taken, with an optional idle burst in front
  task automatic send_level(input logic [7:0] level);
    if (!quiet && $urandom_range(3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.level = level;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    entries.note_level(level);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  // wait for every expected entry, then idle for a margin longer than the pipeline depth
  task automatic drain();
    while (entries.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // sink stalls in random bursts
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(4) == 0) begin
      stall_left <= $urandom_range(5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) entries.check_entry(out_ch.packed_entry);
  end

  initial begin
    logic [7:0] edge_levels [20];
    logic [15:0] strengths [PHASES];
    edge_levels = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd10, 8'd11, 8'd12, 8'd16,
                    8'd32, 8'd64, 8'd85, 8'd127, 8'd128, 8'd170, 8'd192, 8'd240,
                    8'd254, 8'd255};
    // full, none, above full (masked and clamped), half, tiny, just above full, full, partial
    strengths = '{16'd4096, 16'd0, 16'hFFFF, 16'd2048, 16'd1, 16'd4097, 16'd4096, 16'd3000};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values: unity gains, so entries come out as identity
    foreach (edge_levels[i]) send_level(edge_levels[i]);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      quiet = (ph == PHASES - 1);
      write_reg(REG_ENABLE, (ph == 1) ? 16'd0 : 16'd1);
      write_reg(REG_STRENGTH, strengths[ph]);
      if (ph == 2) begin
        // extreme gains: saturation, zero and tiny
        write_reg(REG_RED_GAIN, 16'hFFFF);
        write_reg(REG_GREEN_GAIN, 16'd0);
        write_reg(REG_BLUE_GAIN, 16'd1);
      end else begin
        write_reg(REG_RED_GAIN, 16'($urandom_range(8192)));
        write_reg(REG_GREEN_GAIN, 16'($urandom_range(65535)));
        write_reg(REG_BLUE_GAIN, 16'($urandom_range(6000, 2000)));
      end
      // every order, the two unused codes included
      write_reg(REG_CHANNEL_ORDER, 16'(ph));
      write_reg(REG_SPARE_A, 16'($urandom));
      write_reg(REG_SPARE_B, 16'($urandom));
      if (ph == 2) foreach (edge_levels[i]) send_level(edge_levels[i]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_level(8'($urandom_range(255)));
      drain();
    end

    if (entries.mismatches == 0 && entries.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
